// File: src/lcnc_pkg.sv
package lcnc_pkg;

   localparam int CARD_W         = 64;
   localparam int DIGIT_W        = 4;
   localparam int PREFIX_W       = 7;
   localparam int CLASS_W        = 2;
   localparam int BITS_PER_STEP  = 4;
   localparam int DABBLE_STEPS   = CARD_W / BITS_PER_STEP;
   localparam int MAX_DIGITS_DEF = 19;

   localparam logic [CARD_W-1:0] LONG_LIMIT = 64'd400000000000;

   localparam logic [PREFIX_W-1:0] PFX_LONG_LO = 7'd40;
   localparam logic [PREFIX_W-1:0] PFX_LONG_HI = 7'd50;
   localparam logic [PREFIX_W-1:0] PFX_SHORT_A = 7'd34;
   localparam logic [PREFIX_W-1:0] PFX_SHORT_B = 7'd37;
   localparam logic [PREFIX_W-1:0] PFX_MID_LO  = 7'd51;
   localparam logic [PREFIX_W-1:0] PFX_MID_HI  = 7'd55;

   localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_LONG  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_SHORT = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_MID   = 2'd3;

   // Control shared by every digit cell and the accumulator at the chain end.
   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
   } ctrl_type;

   // Doubled digit with its two decimal digits folded together.
   function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] digit);
      logic [DIGIT_W-1:0] res;
      unique case (digit)
         4'd0:    res = 4'd0;
         4'd1:    res = 4'd2;
         4'd2:    res = 4'd4;
         4'd3:    res = 4'd6;
         4'd4:    res = 4'd8;
         4'd5:    res = 4'd1;
         4'd6:    res = 4'd3;
         4'd7:    res = 4'd5;
         4'd8:    res = 4'd7;
         4'd9:    res = 4'd9;
         default: res = 4'd0;
      endcase
      return res;
   endfunction

endpackage

// File: src/lcnc_digit_cell.sv
module lcnc_digit_cell
   import lcnc_pkg::*;
(
   input  logic                     clock,
   input  ctrl_type                 ctrl,
   input  logic [BITS_PER_STEP-1:0] bits_in,
   input  logic [DIGIT_W-1:0]       digit_in,
   output logic [BITS_PER_STEP-1:0] bits_out,
   output logic [DIGIT_W-1:0]       digit
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] dab_digit;

   // Several shift-and-add-3 steps per cycle; bit j of bits_in is the lower
   // neighbor's carry from step j, and bits_out is ours for the upper one.
   always_comb begin
      logic [DIGIT_W-1:0] d;
      logic [DIGIT_W-1:0] adj;
      d        = digit_ff;
      bits_out = '0;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         adj         = (d >= 4'd5) ? d + 4'd3 : d;
         bits_out[j] = adj[DIGIT_W-1];
         d           = {adj[DIGIT_W-2:0], bits_in[j]};
      end
      dab_digit = d;
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         digit_ff <= '0;
      end else if (ctrl.dabble) begin
         digit_ff <= dab_digit;
      end else if (ctrl.shift) begin
         digit_ff <= digit_in;
      end
   end

   assign digit = digit_ff;

endmodule

// File: src/lcnc_luhn_acc.sv
module lcnc_luhn_acc
   import lcnc_pkg::*;
(
   input  logic                clock,
   input  ctrl_type            ctrl,
   input  logic [DIGIT_W-1:0]  digit,
   input  logic                first,
   input  logic                doubled,
   output logic [DIGIT_W-1:0]  sum,
   output logic [PREFIX_W-1:0] prefix
);

   logic [DIGIT_W-1:0]  sum_ff;
   logic [DIGIT_W-1:0]  sum_in;
   logic [PREFIX_W-1:0] prefix_ff;
   logic [PREFIX_W-1:0] prefix_in;
   logic [DIGIT_W-1:0]  prev_ff;
   logic [DIGIT_W-1:0]  term;
   logic [DIGIT_W:0]    raw_sum;

   always_comb begin
      term    = doubled ? luhn_double(digit) : digit;
      raw_sum = {1'b0, sum_ff} + {1'b0, term};
      sum_in  = (raw_sum >= 5'd10) ? DIGIT_W'(raw_sum - 5'd10) : raw_sum[DIGIT_W-1:0];
      // The most recent nonzero digit and the one below it form the prefix.
      prefix_in = prefix_ff;
      if (digit != '0) begin
         if (first) begin
            prefix_in = PREFIX_W'(digit);
         end else begin
            prefix_in = PREFIX_W'({digit, 3'b000}) + PREFIX_W'({digit, 1'b0})
                        + PREFIX_W'(prev_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         sum_ff    <= '0;
         prefix_ff <= '0;
         prev_ff   <= '0;
      end else if (ctrl.shift) begin
         sum_ff    <= sum_in;
         prefix_ff <= prefix_in;
         prev_ff   <= digit;
      end
   end

   assign sum    = sum_ff;
   assign prefix = prefix_ff;

endmodule

// File: src/luhn_card_number_classifier.sv
// After the edge that takes start, the control runs binary to decimal conversion in the
// digit cell chain (4 bits a cycle), shifts one digit a cycle into the Luhn accumulator,
// classifies, and returns to idle with the result beat out; a new card number is taken
// only in idle, once the previous one is through. The receiver cannot stall. Reset is
// synchronous; it returns the control to idle with no strobe pending.
module luhn_card_number_classifier
   import lcnc_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CARD_W-1:0]   req_card_value,
   output logic                rsp_valid,
   output logic                rsp_checksum_ok,
   output logic [PREFIX_W-1:0] rsp_leading_digits,
   output logic [CLASS_W-1:0]  rsp_issuer_class
);

   localparam int CNT_MAX = (MAX_DIGITS > DABBLE_STEPS) ? MAX_DIGITS : DABBLE_STEPS;
   localparam int CNT_W   = $clog2(CNT_MAX);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DABBLE = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic [CARD_W-1:0]   value_ff;
   logic [CARD_W-1:0]   value_in;
   logic                long_ff;
   logic                long_in;
   logic                ovf_ff;
   logic                ovf_in;
   logic                rsp_valid_ff;
   logic                ok_ff;
   logic                ok_in;
   logic [PREFIX_W-1:0] prefix_ff;
   logic [PREFIX_W-1:0] prefix_in;
   logic [CLASS_W-1:0]  class_ff;
   logic [CLASS_W-1:0]  class_in;
   logic                accept;
   ctrl_type            ctrl;

   logic [BITS_PER_STEP-1:0] carry [0:MAX_DIGITS];
   logic [DIGIT_W-1:0]       digits [0:MAX_DIGITS];
   logic [DIGIT_W-1:0]       acc_sum;
   logic [PREFIX_W-1:0]      acc_prefix;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign ctrl.clear  = accept;
   assign ctrl.dabble = (state_ff == ST_DABBLE);
   assign ctrl.shift  = (state_ff == ST_SCAN);

   // The chain takes the binary value most significant bit first.
   for (genvar j = 0; j < BITS_PER_STEP; j++) begin : g_feed
      assign carry[0][j] = value_ff[CARD_W-1-j];
   end

   assign digits[MAX_DIGITS] = '0;

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      lcnc_digit_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .bits_in  (carry[i]),
         .digit_in (digits[i+1]),
         .bits_out (carry[i+1]),
         .digit    (digits[i])
      );
   end

   lcnc_luhn_acc u_acc (
      .clock   (clock),
      .ctrl    (ctrl),
      .digit   (digits[0]),
      .first   (cnt_ff == '0),
      .doubled (cnt_ff[0]),
      .sum     (acc_sum),
      .prefix  (acc_prefix)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      value_in = value_ff;
      long_in  = long_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DABBLE;
               cnt_in   = '0;
               value_in = req_card_value;
               long_in  = (req_card_value > LONG_LIMIT);
               ovf_in   = 1'b0;
            end
         end
         ST_DABBLE: begin
            value_in = value_ff << BITS_PER_STEP;
            // Any carry out of the top cell means ten to the MAX_DIGITS or more.
            ovf_in   = ovf_ff | (|carry[MAX_DIGITS]);
            if (cnt_ff == CNT_W'(DABBLE_STEPS - 1)) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(MAX_DIGITS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ok_in     = !ovf_ff && (acc_sum == '0);
      prefix_in = ovf_ff ? '0 : acc_prefix;
      class_in  = CLASS_NONE;
      if (ok_in) begin
         if (acc_prefix >= PFX_LONG_LO && acc_prefix < PFX_LONG_HI && long_ff) begin
            class_in = CLASS_LONG;
         end else if (acc_prefix == PFX_SHORT_A || acc_prefix == PFX_SHORT_B) begin
            class_in = CLASS_SHORT;
         end else if (acc_prefix >= PFX_MID_LO && acc_prefix <= PFX_MID_HI) begin
            class_in = CLASS_MID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
      long_ff  <= long_in;
      ovf_ff   <= ovf_in;
      if (state_ff == ST_FINISH) begin
         ok_ff     <= ok_in;
         prefix_ff <= prefix_in;
         class_ff  <= class_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_checksum_ok    = ok_ff;
   assign rsp_leading_digits = prefix_ff;
   assign rsp_issuer_class   = class_ff;

endmodule
